FILE: src/rlmht_pkg.sv
// Shared types and codes for the recency list block.
`timescale 1ns / 1ps

package rlmht_pkg;

   localparam int unsigned ENTRY_W = 7;

   localparam logic [1:0] FUNC_HEAD    = 2'd0;
   localparam logic [1:0] FUNC_TAIL    = 2'd1;
   localparam logic [1:0] FUNC_REBUILD = 2'd2;
   localparam logic [1:0] FUNC_READ    = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [ENTRY_W-1:0] entry;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] entry_out;
      logic               last;
   } rsp_type;

   // One write to a link table, addressed by entry number (1-based).
   typedef struct packed {
      logic               we;
      logic [ENTRY_W-1:0] ent;
      logic [ENTRY_W-1:0] data;
   } link_wr_type;

endpackage

FILE: src/recency_list_move_head_tail.sv
// Top level: length register, link tables and sequencer of the recency list.
// Move to head or tail: link read, then writes in S_UNLINK, S_LINK_K, S_LINK_NB.
// Rebuild: one table row written per cycle by the sweep, rows 1 to length.
// Read out: each word waits for a free output slot, then the next link is read.
// Out-of-range moves give no word and leave the list as it is.
// Reset (synchronous): length = ENTRIES, then a sweep over all rows builds the chain.
`timescale 1ns / 1ps

module recency_list_move_head_tail #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rlmht_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rlmht_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rlmht_pkg::ENTRY_W-1:0] csr_data
);
   import rlmht_pkg::*;

   localparam logic [ENTRY_W-1:0] MAX_LEN = ENTRY_W'(ENTRIES);

   logic [ENTRY_W-1:0] length_ff, length_in;
   logic               csr_write;
   logic [ENTRY_W-1:0] rd_ent;
   logic [ENTRY_W-1:0] next_rd;
   logic [ENTRY_W-1:0] prev_rd;
   link_wr_type        next_wr;
   link_wr_type        prev_wr;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // clamp the written length into 1..ENTRIES
   always_comb begin
      length_in = length_ff;
      if (csr_write) begin
         if (csr_data == '0) begin
            length_in = ENTRY_W'(1);
         end else if (csr_data > MAX_LEN) begin
            length_in = MAX_LEN;
         end else begin
            length_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= MAX_LEN;
      end else begin
         length_ff <= length_in;
      end
   end

   rlmht_link_ram #(.ENTRIES(ENTRIES)) u_next_ram (
      .clock   (clock),
      .wr      (next_wr),
      .rd_ent  (rd_ent),
      .rd_data (next_rd)
   );

   rlmht_link_ram #(.ENTRIES(ENTRIES)) u_prev_ram (
      .clock   (clock),
      .wr      (prev_wr),
      .rd_ent  (rd_ent),
      .rd_data (prev_rd)
   );

   rlmht_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .length        (length_ff),
      .rebuild_start (csr_write),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .rd_ent        (rd_ent),
      .next_rd       (next_rd),
      .prev_rd       (prev_rd),
      .next_wr       (next_wr),
      .prev_wr       (prev_wr)
   );

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      length_ff != '0 && length_ff <= MAX_LEN)
      else $error("list length out of range");

   a_csr_sweep: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_ready)
      else $error("length write did not start a rebuild sweep");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.func == FUNC_READ) |=> !req_ready)
      else $error("read out accepted without a walk");

   a_reset_sweep: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("no clearing sweep after reset");

endmodule

FILE: src/rlmht_link_ram.sv
// One link table: a synchronous memory indexed by entry number.
`timescale 1ns / 1ps

module rlmht_link_ram #(
   parameter int ENTRIES = 64
) (
   input  logic                         clock,
   input  rlmht_pkg::link_wr_type       wr,
   input  logic [rlmht_pkg::ENTRY_W-1:0] rd_ent,
   output logic [rlmht_pkg::ENTRY_W-1:0] rd_data
);
   import rlmht_pkg::*;

   localparam int AW = $clog2(ENTRIES);

   logic [ENTRY_W-1:0] link_mem [ENTRIES];
   logic [ENTRY_W-1:0] rdata_ff;
   logic [ENTRY_W-1:0] wr_off;
   logic [ENTRY_W-1:0] rd_off;

   // entries are numbered from 1; table slots from 0
   assign wr_off = ENTRY_W'(wr.ent - ENTRY_W'(1));
   assign rd_off = ENTRY_W'(rd_ent - ENTRY_W'(1));

   always_ff @(posedge clock) begin
      if (wr.we) begin
         link_mem[wr_off[AW-1:0]] <= wr.data;
      end
      rdata_ff <= link_mem[rd_off[AW-1:0]];
   end

   assign rd_data = rdata_ff;

endmodule

FILE: src/rlmht_seq.sv
// Sequencer: moves, rebuild sweep and read-out walk over the link tables.
`timescale 1ns / 1ps

module rlmht_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rlmht_pkg::ENTRY_W-1:0] length,
   input  logic                          rebuild_start,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rlmht_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rlmht_pkg::rsp_type            rsp_data,
   output logic [rlmht_pkg::ENTRY_W-1:0] rd_ent,
   input  logic [rlmht_pkg::ENTRY_W-1:0] next_rd,
   input  logic [rlmht_pkg::ENTRY_W-1:0] prev_rd,
   output rlmht_pkg::link_wr_type        next_wr,
   output rlmht_pkg::link_wr_type        prev_wr
);
   import rlmht_pkg::*;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_UNLINK,
      S_LINK_K,
      S_LINK_NB,
      S_RO_EMIT,
      S_RO_WAIT
   } state_type;

   localparam logic [ENTRY_W-1:0] ONE  = ENTRY_W'(1);
   localparam logic [ENTRY_W-1:0] NONE = '0;

   state_type          state_ff, state_in;
   logic               to_tail_ff, to_tail_in;
   logic [ENTRY_W-1:0] k_ff, k_in;
   logic [ENTRY_W-1:0] head_ff, head_in;
   logic [ENTRY_W-1:0] tail_ff, tail_in;
   logic [ENTRY_W-1:0] cur_ff, cur_in;
   logic [ENTRY_W-1:0] cnt_ff, cnt_in;
   logic [ENTRY_W-1:0] sweep_ff, sweep_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               accept;
   logic               slot_free;
   logic               is_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_last   = (cur_ff == tail_ff) || (ENTRY_W'(cnt_ff + ONE) == length);

   // Reads are issued only in cycles that write nothing, so no forwarding is needed.
   assign rd_ent = (state_ff == S_RO_EMIT) ? cur_ff : req_data.entry;

   always_comb begin
      state_in     = state_ff;
      to_tail_in   = to_tail_ff;
      k_in         = k_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      next_wr      = '0;
      prev_wr      = '0;

      case (state_ff)
         S_SWEEP: begin
            next_wr.we   = 1'b1;
            next_wr.ent  = sweep_ff;
            next_wr.data = (sweep_ff < length) ? ENTRY_W'(sweep_ff + ONE) : NONE;
            prev_wr.we   = 1'b1;
            prev_wr.ent  = sweep_ff;
            prev_wr.data = ENTRY_W'(sweep_ff - ONE);
            if (sweep_ff >= length) begin
               head_in  = ONE;
               tail_in  = length;
               state_in = S_IDLE;
            end else begin
               sweep_in = ENTRY_W'(sweep_ff + ONE);
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_HEAD, FUNC_TAIL: begin
                     // drop entries outside 1..length
                     if (req_data.entry != NONE && req_data.entry <= length) begin
                        k_in       = req_data.entry;
                        to_tail_in = (req_data.func == FUNC_TAIL);
                        state_in   = S_UNLINK;
                     end
                  end
                  FUNC_REBUILD: begin
                     sweep_in = ONE;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     cur_in   = head_ff;
                     cnt_in   = NONE;
                     state_in = S_RO_EMIT;
                  end
               endcase
            end
         end
         S_UNLINK: begin
            if (prev_rd != NONE) begin
               next_wr.we   = 1'b1;
               next_wr.ent  = prev_rd;
               next_wr.data = next_rd;
            end else begin
               head_in = next_rd;
            end
            if (next_rd != NONE) begin
               prev_wr.we   = 1'b1;
               prev_wr.ent  = next_rd;
               prev_wr.data = prev_rd;
            end else begin
               tail_in = prev_rd;
            end
            state_in = S_LINK_K;
         end
         S_LINK_K: begin
            next_wr.we   = 1'b1;
            next_wr.ent  = k_ff;
            next_wr.data = to_tail_ff ? NONE : head_ff;
            prev_wr.we   = 1'b1;
            prev_wr.ent  = k_ff;
            prev_wr.data = to_tail_ff ? tail_ff : NONE;
            state_in     = S_LINK_NB;
         end
         S_LINK_NB: begin
            if (to_tail_ff) begin
               if (tail_ff != NONE) begin
                  next_wr.we   = 1'b1;
                  next_wr.ent  = tail_ff;
                  next_wr.data = k_ff;
               end else begin
                  head_in = k_ff;
               end
               tail_in = k_ff;
            end else begin
               if (head_ff != NONE) begin
                  prev_wr.we   = 1'b1;
                  prev_wr.ent  = head_ff;
                  prev_wr.data = k_ff;
               end else begin
                  tail_in = k_ff;
               end
               head_in = k_ff;
            end
            state_in = S_IDLE;
         end
         S_RO_EMIT: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.entry_out = cur_ff;
               rsp_data_in.last      = is_last;
               cnt_in                = ENTRY_W'(cnt_ff + ONE);
               state_in              = is_last ? S_IDLE : S_RO_WAIT;
            end
         end
         S_RO_WAIT: begin
            cur_in   = next_rd;
            state_in = S_RO_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a length write restarts the list
      if (rebuild_start) begin
         sweep_in = ONE;
         state_in = S_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= ONE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= ONE;
         tail_ff      <= NONE;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
      to_tail_ff  <= to_tail_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/rlmht_order_checker.sv
// Checker for the recency list: tracks the list order and compares read-out words.
`timescale 1ns / 1ps

module rlmht_order_checker #(
   parameter int ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  rlmht_pkg::req_type            req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  rlmht_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rlmht_pkg::ENTRY_W-1:0] csr_data,
   output int                            fails,
   output int                            pending
);
   import rlmht_pkg::*;

   localparam int SHOWN = 10;

   logic [ENTRY_W-1:0] next_of [0:ENTRIES];
   logic [ENTRY_W-1:0] prev_of [0:ENTRIES];
   logic [ENTRY_W-1:0] head_ent;
   logic [ENTRY_W-1:0] tail_ent;
   logic [ENTRY_W-1:0] list_len;
   rsp_type            order_due[$];

   function automatic void chain_in_order();
      for (int i = 0; i <= ENTRIES; i++) begin
         next_of[i] = '0;
         prev_of[i] = '0;
      end
      for (int i = 1; i <= ENTRIES; i++) begin
         if (i <= list_len) begin
            prev_of[i] = ENTRY_W'(i - 1);
            next_of[i] = (i < list_len) ? ENTRY_W'(i + 1) : '0;
         end
      end
      head_ent = ENTRY_W'(1);
      tail_ent = list_len;
   endfunction

   function automatic void take_length(logic [ENTRY_W-1:0] v);
      logic [ENTRY_W-1:0] s;
      s = v;
      if (s < 1) s = ENTRY_W'(1);
      if (s > ENTRIES) s = ENTRY_W'(ENTRIES);
      list_len = s;
      chain_in_order();
   endfunction

   function automatic void detach(logic [ENTRY_W-1:0] k);
      logic [ENTRY_W-1:0] p;
      logic [ENTRY_W-1:0] n;
      p = prev_of[k];
      n = next_of[k];
      if (p != 0 && p <= ENTRIES) next_of[p] = n;
      else head_ent = n;
      if (n != 0 && n <= ENTRIES) prev_of[n] = p;
      else tail_ent = p;
   endfunction

   function automatic void attach_head(logic [ENTRY_W-1:0] k);
      prev_of[k] = '0;
      next_of[k] = head_ent;
      if (head_ent != 0 && head_ent <= ENTRIES) prev_of[head_ent] = k;
      else tail_ent = k;
      head_ent = k;
   endfunction

   function automatic void attach_tail(logic [ENTRY_W-1:0] k);
      next_of[k] = '0;
      prev_of[k] = tail_ent;
      if (tail_ent != 0 && tail_ent <= ENTRIES) next_of[tail_ent] = k;
      else head_ent = k;
      tail_ent = k;
   endfunction

   // Walk head to tail, at most list_len words; the final word always has last set.
   function automatic void predict_read();
      rsp_type            walk[$];
      rsp_type            w;
      logic [ENTRY_W-1:0] cur;
      int                 cnt;
      logic               done;
      cur  = head_ent;
      cnt  = 0;
      done = 1'b0;
      while (!done && cur != 0 && cur <= ENTRIES && cnt < list_len) begin
         w.entry_out = cur;
         w.last      = (cur == tail_ent) || (cnt + 1 == list_len);
         walk.push_back(w);
         cnt++;
         done = w.last;
         if (!done) cur = next_of[cur];
      end
      if (cnt > 0) walk[cnt-1].last = 1'b1;
      foreach (walk[i]) order_due.push_back(walk[i]);
   endfunction

   function automatic void apply_item(req_type it);
      case (it.func)
         FUNC_HEAD, FUNC_TAIL: begin
            // drop entries outside 1..list_len
            if (it.entry != 0 && it.entry <= list_len) begin
               detach(it.entry);
               if (it.func == FUNC_HEAD) attach_head(it.entry);
               else attach_tail(it.entry);
            end
         end
         FUNC_REBUILD: chain_in_order();
         default: predict_read();
      endcase
   endfunction

   function automatic void check_word(rsp_type got);
      rsp_type want;
      if (order_due.size() == 0) begin
         fails = fails + 1;
         if (fails <= SHOWN)
            $display("%0t: word with nothing expected: entry %0d last %0d",
                     $realtime, got.entry_out, got.last);
      end else begin
         want = order_due.pop_front();
         if (got.entry_out !== want.entry_out || got.last !== want.last) begin
            fails = fails + 1;
            if (fails <= SHOWN)
               $display("%0t: word mismatch: expected entry %0d last %0d, got entry %0d last %0d",
                        $realtime, want.entry_out, want.last, got.entry_out, got.last);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fails    = 0;
         list_len = ENTRY_W'(ENTRIES);
         chain_in_order();
         order_due.delete();
      end else begin
         if (csr_valid && csr_ready) take_length(csr_data);
         if (req_valid && req_ready) apply_item(req_data);
         if (rsp_valid && rsp_ready) check_word(rsp_data);
      end
      pending = order_due.size();
   end

endmodule

FILE: tb/tb_recency_list_move_head_tail.sv
// Testbench top: stimulus, handshake pacing and verdict for the recency list block.
`timescale 1ns / 1ps

module tb_recency_list_move_head_tail;
   import rlmht_pkg::*;

   localparam int ENTRIES     = 64;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 100;
   localparam int PHASE_ITEMS = 22;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [ENTRY_W-1:0] csr_data;
   int                 fails;
   int                 pending;

   int                 send_idle;
   int                 recv_stall;
   logic               hold_off;
   int                 quiet_cycles;
   int                 cur_len;

   recency_list_move_head_tail #(.ENTRIES(ENTRIES)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   rlmht_order_checker #(.ENTRIES(ENTRIES)) u_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .fails     (fails),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver pacing; a hold-off request blocks the result side once for a long stretch.
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] f, logic [ENTRY_W-1:0] e);
      req_data.func  = f;
      req_data.entry = e;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
      while ($urandom_range(99) < send_idle) @(negedge clock);
   endtask

   // Only write the length once all words are out and the block has settled.
   task automatic write_length(logic [ENTRY_W-1:0] v);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_data  = v;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      cur_len   = (v < 1) ? 1 : (v > ENTRIES) ? ENTRIES : v;
   endtask

   task automatic send_random();
      int                 r;
      logic [1:0]         f;
      logic [ENTRY_W-1:0] e;
      r = $urandom_range(99);
      if (r < 40) f = FUNC_HEAD;
      else if (r < 75) f = FUNC_TAIL;
      else if (r < 82) f = FUNC_REBUILD;
      else f = FUNC_READ;
      if ($urandom_range(99) < 10)
         e = ($urandom_range(1) == 0) ? '0 : ENTRY_W'($urandom_range(127, cur_len + 1));
      else
         e = ENTRY_W'($urandom_range(cur_len, 1));
      send_word(f, e);
   endtask

   initial begin
      int phase_len [8];
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      hold_off     = 1'b0;
      send_idle    = 0;
      recv_stall   = 0;
      cur_len      = ENTRIES;
      phase_len    = '{64, 4, 1, 16, -1, 2, 33, -1};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: moves at the ends, ignored entries, rebuild, length writes, read-outs
      send_word(FUNC_READ, '0);
      send_word(FUNC_HEAD, 7'd64);
      send_word(FUNC_TAIL, 7'd1);
      send_word(FUNC_HEAD, 7'd0);
      send_word(FUNC_TAIL, 7'd127);
      send_word(FUNC_HEAD, 7'd65);
      send_word(FUNC_HEAD, 7'd37);
      send_word(FUNC_TAIL, 7'd37);
      send_word(FUNC_READ, 7'd127);
      send_word(FUNC_REBUILD, 7'd0);
      send_word(FUNC_READ, '0);
      write_length(7'd1);
      send_word(FUNC_HEAD, 7'd1);
      send_word(FUNC_TAIL, 7'd1);
      send_word(FUNC_TAIL, 7'd2);
      send_word(FUNC_READ, '0);
      write_length(7'd0);
      send_word(FUNC_READ, '0);
      write_length(7'd127);
      send_word(FUNC_READ, '0);
      write_length(7'd2);
      send_word(FUNC_HEAD, 7'd2);
      send_word(FUNC_READ, '0);
      send_word(FUNC_TAIL, 7'd2);
      send_word(FUNC_HEAD, 7'd3);
      send_word(FUNC_READ, '0);
      write_length(7'd65);
      send_word(FUNC_READ, '0);

      for (int p = 0; p < 8; p++) begin
         if (phase_len[p] < 0) write_length(ENTRY_W'($urandom_range(127)));
         else write_length(ENTRY_W'(phase_len[p]));
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 83; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 83; end
            default: begin send_idle = 7; recv_stall = 7; end
         endcase
         if (p == 3) begin
            // block the result side and keep offering read-outs to fill the block
            hold_off = 1'b1;
            repeat (6) send_word(FUNC_READ, '0);
         end
         repeat (PHASE_ITEMS) send_random();
         send_word(FUNC_READ, '0);
      end

      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (fails == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
